>>> hw/rtl/kce_pkg.sv
// kce_pkg: shared constants, codes, payload and control structs for the
// keypad calculator engine. No dependencies.
`default_nettype none

package kce_pkg;

    localparam int FRAC_DIGITS   = 6;
    localparam int DISPLAY_CHARS = 16;
    localparam int BIN_W         = 50;   // every shown magnitude is below 1e15 < 2^50
    localparam int BCD_DIGITS    = 15;
    localparam int MUL_STEPS     = 64;
    localparam int DIV_STEPS     = 128;

    localparam logic [63:0] SCALE      = 64'd1000000;
    localparam logic [63:0] ROUND_HALF = 64'd500000;
    localparam logic [63:0] OVF_LIM    = 64'd1000000000000000;
    localparam logic [63:0] ENTRY_CAP  = 64'd1000000000000000000;
    localparam logic [63:0] IP_LIM     = 64'd1000000000000;

    localparam logic [3:0] DOT_CODE = 4'd10;

    // key codes
    localparam logic [3:0] KEY_DIGIT = 4'd0;
    localparam logic [3:0] KEY_DOT   = 4'd1;
    localparam logic [3:0] KEY_BACK  = 4'd2;
    localparam logic [3:0] KEY_NEG   = 4'd3;
    localparam logic [3:0] KEY_ADD   = 4'd4;
    localparam logic [3:0] KEY_SUB   = 4'd5;
    localparam logic [3:0] KEY_MUL   = 4'd6;
    localparam logic [3:0] KEY_DIV   = 4'd7;
    localparam logic [3:0] KEY_EQ    = 4'd8;
    localparam logic [3:0] KEY_CLR   = 4'd9;
    localparam logic [3:0] KEY_CE    = 4'd10;
    localparam logic [3:0] KEY_UP    = 4'd11;
    localparam logic [3:0] KEY_DOWN  = 4'd12;
    localparam logic [3:0] KEY_LEFT  = 4'd13;
    localparam logic [3:0] KEY_RIGHT = 4'd14;
    localparam logic [3:0] KEY_PRESS = 4'd15;

    // pending operator codes
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    // display status codes
    localparam logic [1:0] ST_NUMBER   = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;

    localparam logic [4:0] GRID_KEYS = 5'd20;
    localparam logic [4:0] GRID_COLS = 5'd4;
    localparam logic [4:0] HL_RESET  = 5'd4;

    typedef struct packed {
        logic [3:0] func;
        logic [3:0] digit_value;
    } kce_in_t;

    typedef struct packed {
        logic        disp_negative;
        logic [63:0] disp_chars;
        logic [4:0]  disp_len;
        logic [1:0]  disp_status;
        logic [4:0]  selected_button;
        logic [2:0]  pending_op;
    } kce_out_t;

    typedef struct packed {
        logic start;
        logic div_mode;
    } md_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // grid button -> {key code, digit}
    function automatic logic [7:0] grid_action(input logic [4:0] idx);
        logic [7:0] a;
        case (idx)
            5'd0:    a = {KEY_CLR, 4'd0};
            5'd1:    a = {KEY_CE, 4'd0};
            5'd2:    a = {KEY_BACK, 4'd0};
            5'd3:    a = {KEY_DIV, 4'd0};
            5'd4:    a = {KEY_DIGIT, 4'd7};
            5'd5:    a = {KEY_DIGIT, 4'd8};
            5'd6:    a = {KEY_DIGIT, 4'd9};
            5'd7:    a = {KEY_MUL, 4'd0};
            5'd8:    a = {KEY_DIGIT, 4'd4};
            5'd9:    a = {KEY_DIGIT, 4'd5};
            5'd10:   a = {KEY_DIGIT, 4'd6};
            5'd11:   a = {KEY_SUB, 4'd0};
            5'd12:   a = {KEY_DIGIT, 4'd1};
            5'd13:   a = {KEY_DIGIT, 4'd2};
            5'd14:   a = {KEY_DIGIT, 4'd3};
            5'd15:   a = {KEY_ADD, 4'd0};
            5'd16:   a = {KEY_NEG, 4'd0};
            5'd17:   a = {KEY_DIGIT, 4'd0};
            5'd18:   a = {KEY_DOT, 4'd0};
            5'd19:   a = {KEY_EQ, 4'd0};
            default: a = {KEY_PRESS, 4'd0};
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/kce_muldiv.sv
// kce_muldiv: shared iterative unit, shift-add multiply then restoring divide.
// Gives the rounded, clamped magnitude of a*b/1e6 or a*1e6/b. Uses kce_pkg.
`default_nettype none

module kce_muldiv
    import kce_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire md_cmd_t     cmd,
    input  wire logic [63:0] op_a,
    input  wire logic [63:0] op_b,
    output unit_stat_t       stat,
    output logic [63:0]      result
);

    typedef enum logic [4:0] {
        MD_IDLE = 5'b00001,
        MD_MUL  = 5'b00010,
        MD_RND  = 5'b00100,
        MD_DIV  = 5'b01000,
        MD_FIN  = 5'b10000
    } md_state_t;

    md_state_t   state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] hi_reg, hi_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [63:0] dvsr_reg, dvsr_next;
    logic        mode_reg, mode_next;
    logic [63:0] result_reg, result_next;
    logic        done_reg, done_next;

    logic [64:0]  mul_sum;
    logic [64:0]  div_trial;
    logic [64:0]  div_diff;
    logic         div_ge;
    logic [127:0] rnd_sum;
    logic         round_up;
    logic [63:0]  q_low;
    logic         q_big;

    assign mul_sum   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : 65'd0);
    assign div_trial = {rem_reg, hi_reg[63]};
    assign div_diff  = div_trial - {1'b0, dvsr_reg};
    assign div_ge    = div_trial >= {1'b0, dvsr_reg};
    assign rnd_sum   = {hi_reg, lo_reg} + {64'd0, ROUND_HALF};
    // quotient round half up on the remainder, divide mode only
    assign round_up  = mode_reg && ({rem_reg, 1'b0} >= {1'b0, dvsr_reg});
    assign q_low     = lo_reg + {63'd0, round_up};
    assign q_big     = (|hi_reg) || (round_up && (&lo_reg)) || (q_low >= OVF_LIM);

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        rem_next    = rem_reg;
        mcand_next  = mcand_reg;
        dvsr_next   = dvsr_reg;
        mode_next   = mode_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        case (state_reg)
            MD_IDLE: begin
                if (cmd.start) begin
                    mode_next = cmd.div_mode;
                    hi_next   = '0;
                    cnt_next  = '0;
                    if (cmd.div_mode) begin
                        mcand_next = SCALE;
                        lo_next    = op_a;
                        dvsr_next  = op_b;
                    end else begin
                        mcand_next = op_a;
                        lo_next    = op_b;
                        dvsr_next  = SCALE;
                    end
                    state_next = MD_MUL;
                end
            end
            MD_MUL: begin
                hi_next  = mul_sum[64:1];
                lo_next  = {mul_sum[0], lo_reg[63:1]};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(MUL_STEPS - 1)) begin
                    state_next = MD_RND;
                end
            end
            MD_RND: begin
                if (!mode_reg) begin
                    {hi_next, lo_next} = rnd_sum;
                end
                rem_next   = '0;
                cnt_next   = '0;
                state_next = MD_DIV;
            end
            MD_DIV: begin
                rem_next = div_ge ? div_diff[63:0] : div_trial[63:0];
                hi_next  = {hi_reg[62:0], lo_reg[63]};
                lo_next  = {lo_reg[62:0], div_ge};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(DIV_STEPS - 1)) begin
                    state_next = MD_FIN;
                end
            end
            MD_FIN: begin
                result_next = q_big ? OVF_LIM : q_low;
                done_next   = 1'b1;
                state_next  = MD_IDLE;
            end
            default: begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= MD_IDLE;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            mode_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
            mode_reg   <= mode_next;
        end
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        rem_reg    <= rem_next;
        mcand_reg  <= mcand_next;
        dvsr_reg   <= dvsr_next;
        result_reg <= result_next;
    end

    assign stat.busy = (state_reg != MD_IDLE);
    assign stat.done = done_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

>>> hw/rtl/kce_fmt.sv
// kce_fmt: binary to BCD (one shift per cycle) and display formatting of a
// fixed-point magnitude: integer digits, dot, trimmed fraction. Uses kce_pkg.
`default_nettype none

module kce_fmt
    import kce_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [BIN_W-1:0] mag,
    output unit_stat_t            stat,
    output logic [63:0]           chars,
    output logic [4:0]            len
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [5:0]              cnt_reg, cnt_next;
    logic [BIN_W-1:0]        bin_reg, bin_next;
    logic [4*BCD_DIGITS-1:0] bcd_reg, bcd_next;
    logic [4*BCD_DIGITS-1:0] bcd_adj;

    logic [3:0]  ni;
    logic [2:0]  nf;
    logic [35:0] rev_int;
    logic [27:0] frac_word;
    logic [63:0] int_chars;
    logic [63:0] frac_chars;

    // add-3 correction on every digit of five or more
    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            bcd_adj[4*k +: 4] = (bcd_reg[4*k +: 4] >= 4'd5) ? bcd_reg[4*k +: 4] + 4'd3
                                                           : bcd_reg[4*k +: 4];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                cnt_next  = '0;
                bin_next  = mag;
                bcd_next  = '0;
            end
        end else begin
            bcd_next = {bcd_adj[4*BCD_DIGITS-2:0], bin_reg[BIN_W-1]};
            bin_next = {bin_reg[BIN_W-2:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(BIN_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // digits 14..6 are the integer part, 5..0 the fraction
    always_comb begin
        ni = 4'd1;
        for (int k = FRAC_DIGITS; k < BCD_DIGITS; k++) begin
            if (bcd_reg[4*k +: 4] != 4'd0) begin
                ni = 4'(k - FRAC_DIGITS + 1);
            end
        end
        nf = 3'd0;
        for (int j = 0; j < FRAC_DIGITS; j++) begin
            if (bcd_reg[4*(FRAC_DIGITS-1-j) +: 4] != 4'd0) begin
                nf = 3'(j + 1);
            end
        end
        for (int i = 0; i < BCD_DIGITS - FRAC_DIGITS; i++) begin
            rev_int[4*i +: 4] = bcd_reg[4*(BCD_DIGITS-1-i) +: 4];
        end
        frac_word[3:0] = DOT_CODE;
        for (int j = 0; j < FRAC_DIGITS; j++) begin
            frac_word[4*(j+1) +: 4] = bcd_reg[4*(FRAC_DIGITS-1-j) +: 4];
        end
    end

    assign int_chars  = {28'd0, rev_int} >> {(4'd9 - ni), 2'b00};
    assign frac_chars = (nf != 3'd0) ? ({36'd0, frac_word} << {ni, 2'b00}) : 64'd0;

    assign chars     = int_chars | frac_chars;
    assign len       = 5'(ni) + ((nf != 3'd0) ? 5'(nf) + 5'd1 : 5'd0);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

>>> hw/rtl/keypad_calculator_engine_unit.sv
// keypad_calculator_engine_unit: top level, key decode, entry parse and
// sequencer around kce_muldiv and kce_fmt. Uses kce_pkg.
//
//   port group      dir  width  use
//   s_valid/s_ready in   8      key transfer (kce_in_t)
//   m_valid/m_ready out  80     display transfer (kce_out_t)
//   cfg_wr_en/data  in   1+4    entry_char_limit write
//
// Editing, clear and grid keys go from idle straight to the done state. Operator
// and equals keys parse the entry one character a cycle and pad the fraction,
// then, with an operation pending, add/sub directly or multiply/divide on the
// shared shift-add/subtract unit, then convert binary to BCD unless it overflows.
// s_ready is high only when the sequencer is idle; a finished display waits
// in the output register while the next key is taken. Reset is synchronous.
`default_nettype none

module keypad_calculator_engine_unit
    import kce_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire kce_in_t    s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output kce_out_t        m_data,
    input  wire logic       cfg_wr_en,
    input  wire logic [3:0] cfg_wr_data
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_PARSE  = 8'b00000010,
        S_SCALE  = 8'b00000100,
        S_EXEC   = 8'b00001000,
        S_MULDIV = 8'b00010000,
        S_POST   = 8'b00100000,
        S_FMT    = 8'b01000000,
        S_DONE   = 8'b10000000
    } seq_state_t;

    seq_state_t  state_reg, state_next;
    logic [63:0] store_reg, store_next;
    logic [4:0]  len_reg, len_next;
    logic        sign_reg, sign_next;
    logic [63:0] acc_reg, acc_next;
    logic [2:0]  pend_reg, pend_next;
    logic        fresh_reg, fresh_next;
    logic        err_reg, err_next;
    logic        ovf_reg, ovf_next;
    logic [4:0]  hl_reg, hl_next;
    logic [3:0]  limit_reg, limit_next;
    logic [2:0]  key_op_reg, key_op_next;
    logic        is_eq_reg, is_eq_next;
    logic [4:0]  pidx_reg, pidx_next;
    logic [63:0] pv_reg, pv_next;
    logic [2:0]  pnf_reg, pnf_next;
    logic        pdot_reg, pdot_next;
    logic        psat_reg, psat_next;
    logic        pup_reg, pup_next;
    logic        pstop_reg, pstop_next;
    logic [63:0] cur_reg, cur_next;
    logic        neg_reg, neg_next;
    kce_out_t    out_reg, out_next;
    logic        m_valid_reg, m_valid_next;

    logic [7:0]  act;
    logic [3:0]  eff_func;
    logic [3:0]  eff_d;
    logic [3:0]  cur_char;
    logic        has_dot;
    logic        room;
    logic [63:0] pv_x10;
    logic [63:0] pv_up;
    logic [63:0] entry_mag;
    logic [63:0] acc_mag;
    logic [63:0] cur_mag;
    logic [63:0] len_mask;

    md_cmd_t     md_cmd;
    unit_stat_t  md_stat;
    logic [63:0] md_result;
    logic        fmt_start;
    unit_stat_t  fmt_stat;
    logic [63:0] fmt_chars;
    logic [4:0]  fmt_len;

    kce_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (md_cmd),
        .op_a    (acc_mag),
        .op_b    (cur_mag),
        .stat    (md_stat),
        .result  (md_result)
    );

    kce_fmt u_fmt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fmt_start),
        .mag     (acc_mag[BIN_W-1:0]),
        .stat    (fmt_stat),
        .chars   (fmt_chars),
        .len     (fmt_len)
    );

    assign act      = grid_action(hl_reg);
    assign eff_func = (s_data.func == KEY_PRESS) ? act[7:4] : s_data.func;
    assign eff_d    = (s_data.func == KEY_PRESS) ? act[3:0] : s_data.digit_value;
    assign cur_char = store_reg[{pidx_reg[3:0], 2'b00} +: 4];
    assign room     = ((6'(len_reg) + 6'(sign_reg)) < 6'(limit_reg))
                      && (len_reg < 5'(DISPLAY_CHARS));
    assign pv_x10   = (pv_reg << 3) + (pv_reg << 1);
    assign pv_up    = pv_reg + {63'd0, pup_reg};
    assign entry_mag = (psat_reg || pv_up > ENTRY_CAP) ? ENTRY_CAP : pv_up;
    assign acc_mag  = acc_reg[63] ? (64'd0 - acc_reg) : acc_reg;
    assign cur_mag  = cur_reg[63] ? (64'd0 - cur_reg) : cur_reg;

    always_comb begin
        has_dot = 1'b0;
        for (int i = 0; i < DISPLAY_CHARS; i++) begin
            len_mask[4*i +: 4] = (5'(i) < len_reg) ? 4'hF : 4'h0;
            if ((5'(i) < len_reg) && (store_reg[4*i +: 4] == DOT_CODE)) begin
                has_dot = 1'b1;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        store_next   = store_reg;
        len_next     = len_reg;
        sign_next    = sign_reg;
        acc_next     = acc_reg;
        pend_next    = pend_reg;
        fresh_next   = fresh_reg;
        err_next     = err_reg;
        ovf_next     = ovf_reg;
        hl_next      = hl_reg;
        limit_next   = cfg_wr_en ? cfg_wr_data : limit_reg;
        key_op_next  = key_op_reg;
        is_eq_next   = is_eq_reg;
        pidx_next    = pidx_reg;
        pv_next      = pv_reg;
        pnf_next     = pnf_reg;
        pdot_next    = pdot_reg;
        psat_next    = psat_reg;
        pup_next     = pup_reg;
        pstop_next   = pstop_reg;
        cur_next     = cur_reg;
        neg_next     = neg_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        md_cmd       = '0;
        fmt_start    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DONE;
                    pidx_next  = '0;
                    pv_next    = '0;
                    pnf_next   = '0;
                    pdot_next  = 1'b0;
                    psat_next  = 1'b0;
                    pup_next   = 1'b0;
                    pstop_next = 1'b0;
                    case (eff_func)
                        KEY_DIGIT: begin
                            if (eff_d <= 4'd9) begin
                                if (err_reg) begin
                                    acc_next  = '0;
                                    pend_next = OP_NONE;
                                    err_next  = 1'b0;
                                end
                                if (err_reg || fresh_reg) begin
                                    store_next = {60'd0, eff_d};
                                    len_next   = 5'd1;
                                    sign_next  = 1'b0;
                                    ovf_next   = 1'b0;
                                    fresh_next = 1'b0;
                                end else if (!sign_reg && len_reg == 5'd1
                                             && store_reg[3:0] == 4'd0) begin
                                    store_next[3:0] = eff_d;
                                end else if (room) begin
                                    store_next[{len_reg[3:0], 2'b00} +: 4] = eff_d;
                                    len_next = len_reg + 5'd1;
                                end
                            end
                        end
                        KEY_DOT: begin
                            if (err_reg) begin
                                acc_next  = '0;
                                pend_next = OP_NONE;
                                err_next  = 1'b0;
                            end
                            if (err_reg || fresh_reg) begin
                                store_next = {56'd0, DOT_CODE, 4'd0};
                                len_next   = 5'd2;
                                sign_next  = 1'b0;
                                ovf_next   = 1'b0;
                                fresh_next = 1'b0;
                            end else if (!has_dot && room) begin
                                store_next[{len_reg[3:0], 2'b00} +: 4] = DOT_CODE;
                                len_next = len_reg + 5'd1;
                            end
                        end
                        KEY_BACK: begin
                            if (err_reg) begin
                                store_next = '0;
                                len_next   = 5'd1;
                                sign_next  = 1'b0;
                                ovf_next   = 1'b0;
                                acc_next   = '0;
                                pend_next  = OP_NONE;
                                fresh_next = 1'b1;
                                err_next   = 1'b0;
                            end else if (ovf_reg || len_reg <= 5'd1) begin
                                store_next = '0;
                                len_next   = 5'd1;
                                sign_next  = 1'b0;
                                ovf_next   = 1'b0;
                                fresh_next = 1'b1;
                            end else begin
                                len_next = len_reg - 5'd1;
                            end
                        end
                        KEY_NEG: begin
                            if (!err_reg && !ovf_reg) begin
                                if (sign_reg) begin
                                    sign_next = 1'b0;
                                end else if (!(len_reg == 5'd1 && store_reg[3:0] == 4'd0)) begin
                                    sign_next = 1'b1;
                                end
                            end
                        end
                        KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
                            if (!err_reg) begin
                                key_op_next = 3'(eff_func - KEY_NEG);
                                is_eq_next  = 1'b0;
                                state_next  = S_PARSE;
                            end
                        end
                        KEY_EQ: begin
                            if (!err_reg && pend_reg != OP_NONE) begin
                                key_op_next = OP_NONE;
                                is_eq_next  = 1'b1;
                                state_next  = S_PARSE;
                            end
                        end
                        KEY_CLR: begin
                            store_next = '0;
                            len_next   = 5'd1;
                            sign_next  = 1'b0;
                            ovf_next   = 1'b0;
                            acc_next   = '0;
                            pend_next  = OP_NONE;
                            fresh_next = 1'b1;
                            err_next   = 1'b0;
                        end
                        KEY_CE: begin
                            store_next = '0;
                            len_next   = 5'd1;
                            sign_next  = 1'b0;
                            ovf_next   = 1'b0;
                            fresh_next = 1'b1;
                            if (err_reg) begin
                                acc_next  = '0;
                                pend_next = OP_NONE;
                                err_next  = 1'b0;
                            end
                        end
                        KEY_UP: begin
                            if (hl_reg >= GRID_COLS) begin
                                hl_next = hl_reg - GRID_COLS;
                            end
                        end
                        KEY_DOWN: begin
                            if (hl_reg < GRID_KEYS - GRID_COLS) begin
                                hl_next = hl_reg + GRID_COLS;
                            end
                        end
                        KEY_LEFT: begin
                            if (hl_reg[1:0] != 2'd0) begin
                                hl_next = hl_reg - 5'd1;
                            end
                        end
                        KEY_RIGHT: begin
                            if (hl_reg[1:0] != 2'd3) begin
                                hl_next = hl_reg + 5'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_PARSE: begin
                if (pidx_reg == len_reg || pstop_reg) begin
                    state_next = S_SCALE;
                end else begin
                    pidx_next = pidx_reg + 5'd1;
                    if (cur_char == DOT_CODE) begin
                        pdot_next = 1'b1;
                    end else if (cur_char > 4'd9) begin
                        pstop_next = 1'b1;
                    end else if (!pdot_reg) begin
                        if (pv_reg >= IP_LIM) begin
                            psat_next = 1'b1;
                        end else begin
                            pv_next = pv_x10 + {60'd0, cur_char};
                        end
                    end else if (pnf_reg < 3'(FRAC_DIGITS)) begin
                        pv_next  = pv_x10 + {60'd0, cur_char};
                        pnf_next = pnf_reg + 3'd1;
                    end else if (pnf_reg == 3'(FRAC_DIGITS)) begin
                        pup_next = (cur_char >= 4'd5);
                        pnf_next = pnf_reg + 3'd1;
                    end
                end
            end

            S_SCALE: begin
                // pad the fraction out to full scale
                if (pnf_reg < 3'(FRAC_DIGITS)) begin
                    pv_next  = pv_x10;
                    pnf_next = pnf_reg + 3'd1;
                end else begin
                    cur_next   = ovf_reg ? 64'd0
                               : (sign_reg ? (64'd0 - entry_mag) : entry_mag);
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                if (!is_eq_reg && !(pend_reg != OP_NONE && !fresh_reg)) begin
                    acc_next   = cur_reg;
                    pend_next  = key_op_reg;
                    fresh_next = 1'b1;
                    state_next = S_DONE;
                end else begin
                    pend_next  = is_eq_reg ? OP_NONE : key_op_reg;
                    fresh_next = 1'b1;
                    case (pend_reg)
                        OP_ADD: begin
                            acc_next   = acc_reg + cur_reg;
                            state_next = S_POST;
                        end
                        OP_SUB: begin
                            acc_next   = acc_reg - cur_reg;
                            state_next = S_POST;
                        end
                        OP_MUL, OP_DIV: begin
                            if (pend_reg == OP_DIV && cur_reg == 64'd0) begin
                                // divide by zero: latch Error, keep operator on a chain
                                err_next   = 1'b1;
                                acc_next   = '0;
                                store_next = '0;
                                len_next   = 5'd1;
                                sign_next  = 1'b0;
                                ovf_next   = 1'b0;
                                pend_next  = is_eq_reg ? OP_NONE : pend_reg;
                                fresh_next = fresh_reg;
                                state_next = S_DONE;
                            end else begin
                                md_cmd.start    = 1'b1;
                                md_cmd.div_mode = (pend_reg == OP_DIV);
                                neg_next        = acc_reg[63] ^ cur_reg[63];
                                state_next      = S_MULDIV;
                            end
                        end
                        default: begin
                            acc_next   = cur_reg;
                            state_next = S_POST;
                        end
                    endcase
                end
            end

            S_MULDIV: begin
                if (md_stat.done) begin
                    acc_next   = neg_reg ? (64'd0 - md_result) : md_result;
                    state_next = S_POST;
                end
            end

            S_POST: begin
                if (acc_mag >= OVF_LIM) begin
                    store_next = '0;
                    len_next   = 5'd1;
                    sign_next  = 1'b0;
                    ovf_next   = 1'b1;
                    acc_next   = '0;
                    state_next = S_DONE;
                end else begin
                    fmt_start  = 1'b1;
                    state_next = S_FMT;
                end
            end

            S_FMT: begin
                if (fmt_stat.done) begin
                    store_next = fmt_chars;
                    len_next   = fmt_len;
                    sign_next  = acc_reg[63];
                    ovf_next   = 1'b0;
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.disp_negative   = sign_reg;
                    out_next.disp_chars      = store_reg & len_mask;
                    out_next.disp_len        = len_reg;
                    out_next.disp_status     = err_reg ? ST_ERROR
                                             : (ovf_reg ? ST_OVERFLOW : ST_NUMBER);
                    out_next.selected_button = hl_reg;
                    out_next.pending_op      = pend_reg;
                    m_valid_next             = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            store_reg   <= '0;
            len_reg     <= 5'd1;
            sign_reg    <= 1'b0;
            acc_reg     <= '0;
            pend_reg    <= OP_NONE;
            fresh_reg   <= 1'b1;
            err_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
            hl_reg      <= HL_RESET;
            limit_reg   <= 4'd14;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            store_reg   <= store_next;
            len_reg     <= len_next;
            sign_reg    <= sign_next;
            acc_reg     <= acc_next;
            pend_reg    <= pend_next;
            fresh_reg   <= fresh_next;
            err_reg     <= err_next;
            ovf_reg     <= ovf_next;
            hl_reg      <= hl_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
        key_op_reg <= key_op_next;
        is_eq_reg  <= is_eq_next;
        pidx_reg   <= pidx_next;
        pv_reg     <= pv_next;
        pnf_reg    <= pnf_next;
        pdot_reg   <= pdot_next;
        psat_reg   <= psat_next;
        pup_reg    <= pup_next;
        pstop_reg  <= pstop_next;
        cur_reg    <= cur_next;
        neg_reg    <= neg_next;
        out_reg    <= out_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_md_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        md_stat.busy |-> state_reg == S_MULDIV)
        else $error("multiply/divide unit busy outside its sequencer state");

    a_fmt_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        fmt_stat.busy |-> state_reg == S_FMT)
        else $error("format unit busy outside its sequencer state");

    a_one_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("key transfer taken while previous key still in work");

    a_out_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.disp_len != 5'd0 && m_data.disp_len <= 5'(DISPLAY_CHARS)
                     && m_data.disp_status <= ST_ERROR))
        else $error("display result out of range");

endmodule

`default_nettype wire

>>> test/testbench.sv
// testbench: self-checking bench for keypad_calculator_engine_unit.
// Holds a bit-exact key-by-key model of the calculator in a scoreboard class.
// Depends on kce_pkg and the RTL top level only.

module testbench;
    import kce_pkg::*;

    class calc_scoreboard;
        logic [3:0]        chars[DISPLAY_CHARS];
        int                len;
        bit                sign;
        longint            acc;
        logic [2:0]        pend;
        bit                fresh, err, ovf;
        int                hl;
        int                limit;
        kce_out_t          expected_disp[$];
        int                n_checked, n_fail, n_ovf, n_err;

        function new();
            foreach (chars[i]) chars[i] = 0;
            clear_all();
            hl = HL_RESET;
            limit = 14;
            n_checked = 0; n_fail = 0; n_ovf = 0; n_err = 0;
        endfunction

        function void show_zero();
            chars[0] = 0;
            len = 1;
            sign = 0;
            ovf = 0;
        endfunction

        function void clear_all();
            show_zero();
            acc = 0;
            pend = OP_NONE;
            fresh = 1;
            err = 0;
        endfunction

        function longint unsigned mag(longint v);
            return (v < 0) ? 64'(-v) : 64'(v);
        endfunction

        function longint signed_of(longint unsigned m, bit neg);
            return neg ? -longint'(m) : longint'(m);
        endfunction

        function longint entry_value();
            longint unsigned ip, fr, m;
            int nf;
            bit dot, up, sat;
            ip = 0; fr = 0; nf = 0; dot = 0; up = 0; sat = 0;
            if (ovf) return 0;
            for (int i = 0; i < len && i < DISPLAY_CHARS; i++) begin
                if (chars[i] == DOT_CODE) begin
                    dot = 1;
                    continue;
                end
                if (chars[i] > 9) break;
                if (!dot) begin
                    if (ip >= IP_LIM) sat = 1;
                    else ip = ip * 10 + chars[i];
                end else if (nf < FRAC_DIGITS) begin
                    fr = fr * 10 + chars[i];
                    nf++;
                end else if (nf == FRAC_DIGITS) begin
                    up = chars[i] >= 5;
                    nf++;
                end
            end
            for (int i = nf; i < FRAC_DIGITS; i++) fr = fr * 10;
            if (sat || ip >= IP_LIM) m = ENTRY_CAP;
            else m = ip * SCALE + fr + (up ? 1 : 0);
            if (m > ENTRY_CAP) m = ENTRY_CAP;
            return signed_of(m, sign);
        endfunction

        function longint calc(longint a, logic [2:0] op, longint b);
            logic [127:0] p, q, r;
            longint unsigned ma, mb;
            bit neg;
            ma = mag(a); mb = mag(b);
            neg = (a < 0) != (b < 0);
            case (op)
                OP_ADD: return a + b;
                OP_SUB: return a - b;
                OP_MUL: begin
                    p = 128'(ma) * 128'(mb) + 128'(ROUND_HALF);
                    q = p / 128'(SCALE);
                end
                OP_DIV: begin
                    if (mb == 0) begin
                        err = 1;
                        n_err++;
                        return 0;
                    end
                    p = 128'(ma) * 128'(SCALE);
                    q = p / 128'(mb);
                    r = p % 128'(mb);
                    if (2 * r >= 128'(mb)) q = q + 1;
                end
                default: return b;
            endcase
            if (q >= 128'(OVF_LIM)) q = 128'(OVF_LIM);
            return signed_of(q[63:0], neg);
        endfunction

        function void show_acc();
            longint unsigned m, ip, fr;
            logic [3:0] rev[20], fd[FRAC_DIGITS];
            int ni, nf, n;
            m = mag(acc);
            ni = 0; n = 0;
            if (m >= OVF_LIM) begin
                show_zero();
                ovf = 1;
                acc = 0;
                n_ovf++;
                return;
            end
            ip = m / SCALE;
            fr = m % SCALE;
            do begin
                rev[ni++] = 4'(ip % 10);
                ip = ip / 10;
            end while (ip != 0 && ni < 20);
            for (int k = FRAC_DIGITS - 1; k >= 0; k--) begin
                fd[k] = 4'(fr % 10);
                fr = fr / 10;
            end
            nf = FRAC_DIGITS;
            if (ni + 1 + nf > DISPLAY_CHARS) nf = DISPLAY_CHARS - ni - 1;
            while (nf > 0 && fd[nf-1] == 0) nf--;
            for (int k = ni - 1; k >= 0 && n < DISPLAY_CHARS; k--) chars[n++] = rev[k];
            if (nf > 0 && n < DISPLAY_CHARS) begin
                chars[n++] = DOT_CODE;
                for (int k = 0; k < nf && n < DISPLAY_CHARS; k++) chars[n++] = fd[k];
            end
            len = n;
            sign = (acc < 0 && m != 0);
            ovf = 0;
        endfunction

        function bit has_room();
            return (len + sign < limit) && (len < DISPLAY_CHARS);
        endfunction

        function void type_digit(logic [3:0] d);
            if (err) clear_all();
            if (fresh) begin
                chars[0] = d; len = 1; sign = 0; ovf = 0; fresh = 0;
                return;
            end
            if (!sign && len == 1 && chars[0] == 0) begin
                chars[0] = d;
                return;
            end
            if (has_room()) chars[len++] = d;
        endfunction

        function void type_dot();
            if (err) clear_all();
            if (fresh) begin
                chars[0] = 0; chars[1] = DOT_CODE; len = 2; sign = 0; ovf = 0; fresh = 0;
                return;
            end
            for (int i = 0; i < len && i < DISPLAY_CHARS; i++)
                if (chars[i] == DOT_CODE) return;
            if (has_room()) chars[len++] = DOT_CODE;
        endfunction

        function void operator_key(logic [2:0] op);
            longint cur;
            if (err) return;
            cur = entry_value();
            if (pend != OP_NONE && !fresh) begin
                acc = calc(acc, pend, cur);
                if (err) begin
                    show_zero();
                    return;
                end
                show_acc();
            end else begin
                acc = cur;
            end
            pend = op;
            fresh = 1;
        endfunction

        function void equals_key();
            longint cur;
            if (err || pend == OP_NONE) return;
            cur = entry_value();
            acc = calc(acc, pend, cur);
            pend = OP_NONE;
            if (err) begin
                show_zero();
                return;
            end
            show_acc();
            fresh = 1;
        endfunction

        function void apply_key(logic [3:0] f, logic [3:0] d);
            case (f)
                KEY_DIGIT: if (d <= 9) type_digit(d);
                KEY_DOT:   type_dot();
                KEY_BACK: begin
                    if (err) clear_all();
                    else if (ovf || len <= 1) begin
                        show_zero();
                        fresh = 1;
                    end else len--;
                end
                KEY_NEG: begin
                    if (!(err || ovf)) begin
                        if (sign) sign = 0;
                        else if (!(len == 1 && chars[0] == 0)) sign = 1;
                    end
                end
                KEY_ADD:   operator_key(OP_ADD);
                KEY_SUB:   operator_key(OP_SUB);
                KEY_MUL:   operator_key(OP_MUL);
                KEY_DIV:   operator_key(OP_DIV);
                KEY_EQ:    equals_key();
                KEY_CLR:   clear_all();
                KEY_CE: begin
                    if (err) clear_all();
                    else begin
                        show_zero();
                        fresh = 1;
                    end
                end
                KEY_UP:    if (hl >= 4) hl -= 4;
                KEY_DOWN:  if (hl < 16) hl += 4;
                KEY_LEFT:  if (hl % 4 != 0) hl--;
                KEY_RIGHT: if (hl % 4 != 3) hl++;
                default: ;
            endcase
        endfunction

        // grid: C CE BS / | 7 8 9 * | 4 5 6 - | 1 2 3 + | +/- 0 . =
        function void press_highlighted();
            case (hl)
                0:  apply_key(KEY_CLR, 0);
                1:  apply_key(KEY_CE, 0);
                2:  apply_key(KEY_BACK, 0);
                3:  apply_key(KEY_DIV, 0);
                4:  apply_key(KEY_DIGIT, 7);
                5:  apply_key(KEY_DIGIT, 8);
                6:  apply_key(KEY_DIGIT, 9);
                7:  apply_key(KEY_MUL, 0);
                8:  apply_key(KEY_DIGIT, 4);
                9:  apply_key(KEY_DIGIT, 5);
                10: apply_key(KEY_DIGIT, 6);
                11: apply_key(KEY_SUB, 0);
                12: apply_key(KEY_DIGIT, 1);
                13: apply_key(KEY_DIGIT, 2);
                14: apply_key(KEY_DIGIT, 3);
                15: apply_key(KEY_ADD, 0);
                16: apply_key(KEY_NEG, 0);
                17: apply_key(KEY_DIGIT, 0);
                18: apply_key(KEY_DOT, 0);
                19: apply_key(KEY_EQ, 0);
                default: ;
            endcase
        endfunction

        function void note_key(kce_in_t k);
            kce_out_t o;
            if (k.func == KEY_PRESS) press_highlighted();
            else apply_key(k.func, k.digit_value);
            o = '0;
            for (int i = 0; i < len && i < DISPLAY_CHARS; i++) o.disp_chars[4*i +: 4] = chars[i];
            o.disp_negative   = sign;
            o.disp_len        = 5'(len);
            o.disp_status     = err ? ST_ERROR : (ovf ? ST_OVERFLOW : ST_NUMBER);
            o.selected_button = 5'(hl);
            o.pending_op      = pend;
            expected_disp.push_back(o);
        endfunction

        function void check_display(kce_out_t got);
            kce_out_t e;
            if (expected_disp.size() == 0) begin
                $error("display transfer with nothing expected");
                n_fail++;
                return;
            end
            e = expected_disp.pop_front();
            n_checked++;
            if (got.disp_negative !== e.disp_negative) begin
                $error("disp_negative exp %0d got %0d", e.disp_negative, got.disp_negative);
                n_fail++;
            end
            if (got.disp_chars !== e.disp_chars) begin
                $error("disp_chars exp %h got %h", e.disp_chars, got.disp_chars);
                n_fail++;
            end
            if (got.disp_len !== e.disp_len) begin
                $error("disp_len exp %0d got %0d", e.disp_len, got.disp_len);
                n_fail++;
            end
            if (got.disp_status !== e.disp_status) begin
                $error("disp_status exp %0d got %0d", e.disp_status, got.disp_status);
                n_fail++;
            end
            if (got.selected_button !== e.selected_button) begin
                $error("selected_button exp %0d got %0d", e.selected_button,
                       got.selected_button);
                n_fail++;
            end
            if (got.pending_op !== e.pending_op) begin
                $error("pending_op exp %0d got %0d", e.pending_op, got.pending_op);
                n_fail++;
            end
        endfunction
    endclass

    logic       aclk = 0;
    logic       aresetn = 0;
    logic       s_valid = 0;
    logic       s_ready;
    kce_in_t    s_data = '0;
    logic       m_valid;
    logic       m_ready = 0;
    kce_out_t   m_data;
    logic       cfg_wr_en = 0;
    logic [3:0] cfg_wr_data = 0;

    calc_scoreboard sb = new();
    int keys_sent = 0;
    int burst_left = 0;
    int n_cfg = 0;

    keypad_calculator_engine_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_display(m_data);
    end

    // receiver: random ready pattern, one long hold-off to back up the pipe
    initial begin
        int cyc, mode;
        cyc = 0; mode = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc == 3000) begin
                m_ready <= 0;
                repeat (2000) @(posedge aclk);
            end
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: m_ready <= 1;
                1: m_ready <= $urandom_range(0, 1);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ((cyc % 8) < 5);
            endcase
        end
    end

    task automatic send_key(logic [3:0] f, logic [3:0] d);
        kce_in_t k;
        k.func = f;
        k.digit_value = d;
        s_valid <= 1;
        s_data  <= k;
        do @(posedge aclk); while (!s_ready);
        sb.note_key(k);
        keys_sent++;
        if (burst_left > 0) burst_left--;
        else begin
            s_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
    endtask

    task automatic write_limit(logic [3:0] v);
        s_valid <= 0;
        while (sb.expected_disp.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.limit = v;
        n_cfg++;
    endtask

    task automatic enter_number();
        int n, dot_at;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 18) : $urandom_range(1, 6);
        dot_at = ($urandom_range(0, 1) == 0) ? $urandom_range(0, n) : -1;
        for (int i = 0; i < n; i++) begin
            if (i == dot_at) send_key(KEY_DOT, 0);
            else if ($urandom_range(0, 4) == 0) send_key(KEY_DIGIT, 9);
            else if ($urandom_range(0, 6) == 0) send_key(KEY_DIGIT, 0);
            else send_key(KEY_DIGIT, 4'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 3) == 0) send_key(KEY_NEG, 0);
    endtask

    task automatic random_keys(int target);
        int stop_at;
        stop_at = keys_sent + target;
        while (keys_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    enter_number();
                    send_key(4'($urandom_range(KEY_ADD, KEY_DIV)), 0);
                    if ($urandom_range(0, 5) == 0) send_key(KEY_DIGIT, 0);
                    else enter_number();
                    if ($urandom_range(0, 2) == 0)
                        send_key(4'($urandom_range(KEY_ADD, KEY_DIV)), 0);
                    else send_key(KEY_EQ, 0);
                end
                6, 7: send_key(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
                8: begin
                    repeat ($urandom_range(1, 6))
                        send_key(4'($urandom_range(KEY_UP, KEY_RIGHT)), 0);
                    send_key(KEY_PRESS, 4'($urandom_range(0, 15)));
                end
                default:
                    send_key(4'($urandom_range(KEY_BACK, KEY_NEG)), 4'($urandom_range(0, 15)));
            endcase
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: entry edits, rounding, saturation, errors, overflow, grid
        send_key(KEY_NEG, 0);                 // negate on plain zero
        send_key(KEY_DIGIT, 15);              // ignored digit code
        send_key(KEY_DOT, 0);
        repeat (7) send_key(KEY_DIGIT, 9);    // seventh decimal rounds up
        send_key(KEY_NEG, 0);
        send_key(KEY_DIV, 0);
        send_key(KEY_DIGIT, 0);
        send_key(KEY_EQ, 0);                  // divide by zero
        send_key(KEY_ADD, 0);                 // ignored while in error
        send_key(KEY_BACK, 0);
        repeat (14) send_key(KEY_DIGIT, 9);   // huge entry saturates
        send_key(KEY_MUL, 0);
        send_key(KEY_EQ, 0);                  // overflow
        send_key(KEY_NEG, 0);
        send_key(KEY_BACK, 0);
        send_key(KEY_CE, 0);
        send_key(KEY_CLR, 0);
        repeat (5) send_key(KEY_UP, 0);
        repeat (5) send_key(KEY_LEFT, 0);
        for (int i = 0; i < 20; i++) begin
            send_key(KEY_PRESS, 0);
            send_key((i % 4 == 3) ? KEY_DOWN : KEY_RIGHT, 0);
            if (i % 4 == 3) repeat (3) send_key(KEY_LEFT, 0);
        end
        send_key(KEY_DOWN, 0);
        send_key(KEY_RIGHT, 0);

        random_keys(140);
        write_limit(2);
        random_keys(110);
        write_limit(0);
        random_keys(60);
        write_limit(15);
        random_keys(140);
        write_limit(1);
        random_keys(60);
        write_limit(14);
        random_keys(110);
        write_limit(4'($urandom_range(3, 13)));
        random_keys(110);

        s_valid <= 0;
        while (sb.expected_disp.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("ran %0d keys over %0d limit settings, %0d displays checked",
                 keys_sent, n_cfg + 1, sb.n_checked);
        $display("model saw %0d overflows and %0d divide-by-zero errors", sb.n_ovf, sb.n_err);
        if (sb.n_fail == 0 && sb.expected_disp.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #60000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
